// ----- rtl/rau_pkg.sv -----
`default_nettype none
package rau_pkg;
	localparam int unsigned DataW = 32;
	localparam int unsigned CntW = 5;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DIV_ZERO = 2'd1,
		ST_DEN_ZERO = 2'd2,
		ST_RSVD     = 2'd3
	} stat_t;

	// divider handshake
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/rau_div.sv -----
`default_nettype none
// Signed truncating divider, one quotient bit per cycle.
module rau_div
	import rau_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire  div_req_t          req,
	input  wire  logic [DataW-1:0]  dividend,
	input  wire  logic [DataW-1:0]  divisor,
	output div_rsp_t                rsp,
	output logic [DataW-1:0]        quo,
	output logic [DataW-1:0]        rem
);
	logic [DataW-1:0] q_q, r_q, d_q;
	logic             nq_q, nr_q, busy_q, done_q;
	logic [CntW-1:0]  cnt_q;
	logic [DataW:0]   trial;
	logic [DataW-1:0] rsh;

	assign rsh   = {r_q[DataW-2:0], q_q[DataW-1]};
	assign trial = {1'b0, rsh} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DataW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q  <= dividend[DataW-1] ? (~dividend + 1'b1) : dividend;
			d_q  <= divisor[DataW-1] ? (~divisor + 1'b1) : divisor;
			r_q  <= '0;
			nq_q <= dividend[DataW-1] ^ divisor[DataW-1];
			nr_q <= dividend[DataW-1];
		end else if (busy_q) begin
			// remainder wider than a bit fits: magnitudes are at most 2^31
			if (!trial[DataW]) begin
				r_q <= trial[DataW-1:0];
				q_q <= {q_q[DataW-2:0], 1'b1};
			end else begin
				r_q <= rsh;
				q_q <= {q_q[DataW-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign quo = nq_q ? (~q_q + 1'b1) : q_q;
	assign rem = nr_q ? (~r_q + 1'b1) : r_q;

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(busy_q)) else $error("done without busy");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start |=> busy_q || done_q) else $error("lost op");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> cnt_q == '0) else $error("count not cleared");
`endif
endmodule
`default_nettype wire

// ----- rtl/rational_arith_unit_top.sv -----
`default_nettype none
// Rational arithmetic unit: adds, subtracts, multiplies or divides two
// signed 32-bit fractions and reduces the result by Euclid's algorithm.
// Input beat (s_axis): tdata = {b_den, b_num, a_den, a_num}, tuser = action.
// Output beat (m_axis): tdata = {res_den, res_num}, tuser = status.
// One item at a time: s_axis_tready is high whenever the sequencer is idle.
// The output register holds the previous result while the next item runs.
// Cross products use one 32x32 multiplier, one product per cycle (S_MUL0-2).
// Reduction runs Euclid steps on a shared radix-2 divider; a 32-bit pair
// needs up to about 46 steps, then two more divisions for the final
// quotients. Error items skip the divider. The sequencer returns to idle
// as a result loads into the output register.
// Reset clears the sequencer and the output valid; an item in flight and
// an unaccepted output beat are dropped.
// A stalled output holds its beat; a finished item waits for the register.
module rational_arith_unit_top
	import rau_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
	input  wire  [1:0]   s_axis_tuser,  // action
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // res_num, res_den
	output logic [1:0]   m_axis_tuser   // status
);
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MUL0 = 9'b000000010,
		S_MUL1 = 9'b000000100,
		S_MUL2 = 9'b000001000,
		S_CHK  = 9'b000010000,
		S_EUC  = 9'b000100000,
		S_QN   = 9'b001000000,
		S_QD   = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic [DataW-1:0] an_q, ad_q, bn_q, bd_q;
	logic [DataW-1:0] p_q, n_q, d_q, x_q, y_q, rn_q, rd_q;
	stat_t            st_q;
	logic [DataW-1:0] ma, mb, prod;
	logic             wait_q;
	logic             out_v_q;
	logic [DataW-1:0] on_q, od_q;
	stat_t            os_q;
	div_req_t         dreq;
	div_rsp_t         drsp;
	logic [DataW-1:0] dnd, dsr, quo, rem;

	assign s_axis_tready = (state_q == S_IDLE);

	// multiplier operand select, one product per step
	always_comb begin
		ma = an_q;
		mb = bd_q;
		unique case (state_q)
			S_MUL0: begin
				ma = an_q;
				mb = (op_q == OP_MUL) ? bn_q : bd_q;
			end
			S_MUL1: begin
				ma = bn_q;
				mb = ad_q;
			end
			S_MUL2: begin
				ma = ad_q;
				mb = (op_q == OP_DIV) ? bn_q : bd_q;
			end
			default: begin
				ma = an_q;
				mb = bd_q;
			end
		endcase
	end
	assign prod = DataW'(ma * mb);

	always_comb begin
		dreq.start = 1'b0;
		dnd = x_q;
		dsr = y_q;
		unique case (state_q)
			S_QN: begin
				dnd = n_q;
				dsr = x_q;
			end
			S_QD: begin
				dnd = d_q;
				dsr = x_q;
			end
			default: begin
				dnd = x_q;
				dsr = y_q;
			end
		endcase
		if ((state_q == S_EUC || state_q == S_QN || state_q == S_QD) && !wait_q)
			dreq.start = !(state_q == S_EUC && y_q == '0);
	end

	rau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (dreq),
		.dividend (dnd),
		.divisor  (dsr),
		.rsp      (drsp),
		.quo      (quo),
		.rem      (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
			wait_q  <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					state_q <= S_MUL0;
				end
				S_MUL0: state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_CHK;
				S_CHK: begin
					wait_q <= 1'b0;
					if (ad_q == '0 || bd_q == '0 || (op_q == OP_DIV && bn_q == '0) ||
						d_q == '0)
						state_q <= S_OUT;
					else
						state_q <= S_EUC;
				end
				S_EUC: begin
					if (!wait_q) begin
						if (y_q == '0) state_q <= S_QN;
						else wait_q <= 1'b1;
					end else if (drsp.done) begin
						wait_q <= 1'b0;
					end
				end
				S_QN: begin
					if (!wait_q) wait_q <= 1'b1;
					else if (drsp.done) begin
						wait_q  <= 1'b0;
						state_q <= S_QD;
					end
				end
				S_QD: begin
					if (!wait_q) wait_q <= 1'b1;
					else if (drsp.done) begin
						wait_q  <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_OUT: if (!out_v_q) begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q <= op_t'(s_axis_tuser);
				an_q <= s_axis_tdata[31:0];
				ad_q <= s_axis_tdata[63:32];
				bn_q <= s_axis_tdata[95:64];
				bd_q <= s_axis_tdata[127:96];
			end
			S_MUL0: p_q <= prod;
			S_MUL1: begin
				unique case (op_q)
					OP_ADD:  n_q <= p_q + prod;
					OP_SUB:  n_q <= p_q - prod;
					default: n_q <= p_q;
				endcase
			end
			S_MUL2: d_q <= prod;
			S_CHK: begin
				x_q <= n_q;
				y_q <= d_q;
				// given zero denominator wins over divide by zero, then wrap to zero
				priority if (ad_q == '0 || bd_q == '0)
					st_q <= ST_DEN_ZERO;
				else if (op_q == OP_DIV && bn_q == '0)
					st_q <= ST_DIV_ZERO;
				else if (d_q == '0)
					st_q <= ST_DEN_ZERO;
				else
					st_q <= ST_OK;
			end
			S_EUC: if (wait_q && drsp.done) begin
				x_q <= y_q;
				y_q <= rem;
			end
			S_QN: if (wait_q && drsp.done) rn_q <= quo;
			S_QD: if (wait_q && drsp.done) rd_q <= quo;
			S_OUT: if (!out_v_q) begin
				on_q <= (st_q == ST_OK) ? rn_q : '0;
				od_q <= (st_q == ST_OK) ? rd_q : DataW'(1);
				os_q <= st_q;
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {od_q, on_q};
	assign m_axis_tuser  = os_q;

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser)) else $error("output beat changed while stalled");
	a_ok_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_OK |-> m_axis_tdata[63:32] != '0)
		else $error("zero denominator on ok");
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[31:0] == '0)
		else $error("error result not zero");
	a_div_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> !drsp.busy) else $error("divider restarted");
`endif
endmodule
`default_nettype wire
